>>> hdl/rza_pkg.sv
// Shared types and constants for the rolling z-score anomaly detector.
package rza_pkg;

   // Score format: unsigned Q1.15, one extra integer bit so 1.0 fits
   localparam int SCORE_W    = 16;
   localparam int SCORE_FRAC = 15;
   localparam int NUM_LANES  = 3;
   localparam int ZFS_W      = 4;
   localparam int ZFS_SQ_W   = 2 * ZFS_W;
   localparam logic [ZFS_W-1:0] ZFS_RESET = 4'd3;
   localparam logic [SCORE_W-1:0] SCORE_ONE = 16'h8000;

   // Operation a lane performs in the current cycle
   typedef enum logic [2:0] {
      LN_NOP,
      LN_CLEAR,
      LN_ACC,
      LN_PREP1,
      LN_PREP2,
      LN_PREP3,
      LN_SEARCH
   } lane_op_type;

   typedef logic [SCORE_W-1:0] score_type;

endpackage

>>> hdl/rolling_zscore_anomaly.sv
// Top level of the rolling z-score anomaly detector.
//
//   channel  direction  ports                                       beat when
//   req      in         req_valence_in/arousal_in/dominance_in,     req_valid & !req_stall
//                       req_run_start, req_short_run
//   rsp      out        rsp_anomaly_score                           rsp_valid & !rsp_stall
//   csr      in         csr_wr_en, csr_wr_data (z full scale)       csr_wr_en
//
// Each item runs, after accept, through these steps, n = samples in the
// window (1 to PAST_WINDOW + 1): one read of the store per window sample, a
// drain step, three setup steps, a 16-step score search in each lane, a
// merge step and the output load; no new item is accepted until the block
// is idle again.
// Reset is synchronous; it empties the window and restores full scale 3.
// The next beat is taken once the current result sits in the output
// register; a stalled result holds the block in its last step.
module rolling_zscore_anomaly #(
   parameter int SAMPLE_BITS = 16,
   parameter int PAST_WINDOW = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SAMPLE_BITS-1:0]   req_valence_in,
   input  logic signed [SAMPLE_BITS-1:0]   req_arousal_in,
   input  logic signed [SAMPLE_BITS-1:0]   req_dominance_in,
   input  logic                            req_run_start,
   input  logic                            req_short_run,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rza_pkg::SCORE_W-1:0]     rsp_anomaly_score,
   input  logic                            csr_wr_en,
   input  logic [rza_pkg::ZFS_W-1:0]       csr_wr_data
);

   localparam int CNT_W = $clog2(PAST_WINDOW + 2);
   localparam int IDX_W = (PAST_WINDOW > 1) ? $clog2(PAST_WINDOW) : 1;
   localparam int SRCH_W = $clog2(rza_pkg::SCORE_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_PREP1,
      ST_PREP2,
      ST_PREP3,
      ST_SEARCH,
      ST_MERGE,
      ST_OUT
   } state_type;

   typedef logic [rza_pkg::NUM_LANES-1:0][SAMPLE_BITS-1:0] sample_vec_type;

   state_type                   state_ff;
   sample_vec_type              win_mem [PAST_WINDOW];
   sample_vec_type              cur_ff;
   sample_vec_type              rd_data_ff;
   logic                        rd_vld_ff;
   logic [CNT_W-1:0]            rd_cnt_ff;
   logic [CNT_W-1:0]            fill_ff;
   logic [IDX_W-1:0]            slot_ff;
   logic                        short_ff;
   logic [SRCH_W-1:0]           srch_ff;
   logic [rza_pkg::ZFS_W-1:0]   zfs_ff;
   logic                        rsp_valid_ff;
   rza_pkg::score_type          rsp_score_ff;

   logic                        req_beat;
   logic                        out_free;
   logic [CNT_W-1:0]            count_w;
   logic [rza_pkg::ZFS_W-1:0]   zfs_eff;
   logic [rza_pkg::ZFS_SQ_W-1:0] zfs_sq;
   rza_pkg::lane_op_type        lane_op;
   rza_pkg::score_type          lane_score [rza_pkg::NUM_LANES];
   rza_pkg::score_type          best;

   assign req_beat  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign count_w   = fill_ff + CNT_W'(1);
   assign zfs_eff   = (zfs_ff == '0) ? rza_pkg::ZFS_W'(1) : zfs_ff;
   assign zfs_sq    = rza_pkg::ZFS_SQ_W'(zfs_eff) * rza_pkg::ZFS_SQ_W'(zfs_eff);

   // lane operation follows the sequencer
   always_comb begin
      unique case (state_ff)
         ST_IDLE:   lane_op = req_beat ? rza_pkg::LN_CLEAR : rza_pkg::LN_NOP;
         ST_READ:   lane_op = rd_vld_ff ? rza_pkg::LN_ACC : rza_pkg::LN_NOP;
         ST_DRAIN:  lane_op = rza_pkg::LN_ACC;
         ST_PREP1:  lane_op = rza_pkg::LN_PREP1;
         ST_PREP2:  lane_op = rza_pkg::LN_PREP2;
         ST_PREP3:  lane_op = rza_pkg::LN_PREP3;
         ST_SEARCH: lane_op = rza_pkg::LN_SEARCH;
         default:   lane_op = rza_pkg::LN_NOP;
      endcase
   end

   // one lane per dimension
   for (genvar g = 0; g < rza_pkg::NUM_LANES; g++) begin : g_lane
      rza_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .PAST_WINDOW (PAST_WINDOW)
      ) u_lane (
         .clock   (clock),
         .lane_op (lane_op),
         .sample  (signed'(rd_data_ff[g])),
         .count   (count_w),
         .zfs_sq  (zfs_sq),
         .score   (lane_score[g])
      );
   end

   rza_merge u_merge (
      .clock      (clock),
      .load       (state_ff == ST_MERGE),
      .lane_score (lane_score),
      .short_run  (short_ff),
      .best       (best)
   );

   // sequencer, window store and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         slot_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         zfs_ff       <= rza_pkg::ZFS_RESET;
      end else begin
         if (csr_wr_en) begin
            zfs_ff <= csr_wr_data;
         end
         // the output step reloads the register on its own
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  cur_ff    <= {req_dominance_in, req_arousal_in, req_valence_in};
                  short_ff  <= req_short_run;
                  rd_cnt_ff <= '0;
                  if (req_run_start) begin
                     fill_ff <= '0;
                     slot_ff <= '0;
                  end
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               // past samples first, current sample last
               if (rd_cnt_ff < fill_ff) begin
                  rd_data_ff <= win_mem[rd_cnt_ff[IDX_W-1:0]];
               end else begin
                  rd_data_ff <= cur_ff;
                  state_ff   <= ST_DRAIN;
               end
               rd_vld_ff <= 1'b1;
               rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
            end
            ST_DRAIN: begin
               rd_vld_ff <= 1'b0;
               state_ff  <= ST_PREP1;
            end
            ST_PREP1: state_ff <= ST_PREP2;
            ST_PREP2: state_ff <= ST_PREP3;
            ST_PREP3: begin
               srch_ff  <= SRCH_W'(rza_pkg::SCORE_W - 1);
               state_ff <= ST_SEARCH;
            end
            ST_SEARCH: begin
               srch_ff <= srch_ff - SRCH_W'(1);
               if (srch_ff == '0) begin
                  state_ff <= ST_MERGE;
               end
            end
            ST_MERGE: begin
               // store the sample; oldest entry is overwritten when full
               win_mem[slot_ff] <= cur_ff;
               slot_ff <= (slot_ff == IDX_W'(PAST_WINDOW - 1)) ? '0 : slot_ff + IDX_W'(1);
               if (fill_ff < CNT_W'(PAST_WINDOW)) begin
                  fill_ff <= fill_ff + CNT_W'(1);
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_score_ff <= best;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_anomaly_score = rsp_score_ff;

   // score never exceeds 1.0
   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_anomaly_score <= rza_pkg::SCORE_ONE))
      else $error("score above full scale");

   // window count stays within the store
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(PAST_WINDOW))
      else $error("window fill out of range");

   // an accepted beat starts the read sweep
   a_beat_read: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_READ))
      else $error("beat did not start processing");

   // a finished result reaches the output register when it is free
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && out_free |=> rsp_valid && (state_ff == ST_IDLE))
      else $error("result not presented");

endmodule

>>> hdl/rza_lane.sv
// One dimension lane: window statistics and bit-serial score search.
module rza_lane #(
   parameter int SAMPLE_BITS = 16,
   parameter int PAST_WINDOW = 5,
   localparam int CNT_W = $clog2(PAST_WINDOW + 2)
) (
   input  logic                          clock,
   input  rza_pkg::lane_op_type          lane_op,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [CNT_W-1:0]              count,
   input  logic [rza_pkg::ZFS_SQ_W-1:0]  zfs_sq,
   output rza_pkg::score_type            score
);

   localparam int SUM_W = SAMPLE_BITS + CNT_W;
   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int Q_W   = SQ_W + CNT_W;
   localparam int NQ_W  = Q_W + CNT_W;
   localparam int S2_W  = 2 * SUM_W;
   localparam int D_W   = SUM_W + 1;
   localparam int D2_W  = 2 * D_W;
   localparam int A_W   = NQ_W + rza_pkg::ZFS_SQ_W;
   localparam int B_W   = D2_W + 2 * rza_pkg::SCORE_FRAC;
   localparam int T_W   = A_W + 2 * rza_pkg::SCORE_W;
   localparam int P_W   = (T_W > B_W ? T_W : B_W) + 2;

   logic signed [SUM_W-1:0]       s_sum_ff;
   logic [Q_W-1:0]                q_sum_ff;
   logic signed [SAMPLE_BITS-1:0] last_ff;
   logic [S2_W-1:0]               s2_ff;
   logic [NQ_W-1:0]               nq_ff;
   logic signed [D_W-1:0]         d_ff;
   logic [NQ_W-1:0]               v_ff;
   logic [D2_W-1:0]               d2_ff;
   logic [P_W-1:0]                b_ff;
   logic [P_W-1:0]                p_ff;
   logic [P_W-1:0]                f_ff;
   logic [P_W-1:0]                e_ff;
   logic                          vzero_ff;
   logic                          first_ff;
   logic                          sat_ff;
   rza_pkg::score_type            s_ff;

   logic signed [SQ_W-1:0]  sq_w;
   logic signed [S2_W-1:0]  s2_w;
   logic signed [D_W-1:0]   nx_w;
   logic signed [D_W-1:0]   d_w;
   logic [D_W-1:0]          dabs_w;
   logic [A_W-1:0]          a_w;
   logic [P_W-1:0]          cand_w;
   logic                    take_w;

   // Arithmetic feeding the per-phase registers
   assign sq_w   = sample * sample;
   assign s2_w   = S2_W'(s_sum_ff) * S2_W'(s_sum_ff);
   assign nx_w   = D_W'(last_ff) * signed'(D_W'(count));
   assign d_w    = nx_w - D_W'(s_sum_ff);
   assign dabs_w = d_ff[D_W-1] ? D_W'(-d_ff) : D_W'(d_ff);
   assign a_w    = A_W'(v_ff) * A_W'(zfs_sq);

   // Candidate (s + 2^k)^2 * A built from running terms
   assign cand_w = p_ff + f_ff + e_ff;
   assign take_w = (cand_w <= b_ff) && !sat_ff;

   always_ff @(posedge clock) begin
      unique case (lane_op)
         rza_pkg::LN_CLEAR: begin
            s_sum_ff <= '0;
            q_sum_ff <= '0;
         end
         rza_pkg::LN_ACC: begin
            s_sum_ff <= s_sum_ff + SUM_W'(sample);
            q_sum_ff <= q_sum_ff + Q_W'($unsigned(sq_w));
            last_ff  <= sample;
         end
         rza_pkg::LN_PREP1: begin
            s2_ff <= $unsigned(s2_w);
            nq_ff <= NQ_W'(q_sum_ff) * NQ_W'(count);
            d_ff  <= d_w;
         end
         rza_pkg::LN_PREP2: begin
            v_ff  <= nq_ff - NQ_W'(s2_ff);
            d2_ff <= D2_W'(dabs_w) * D2_W'(dabs_w);
         end
         rza_pkg::LN_PREP3: begin
            b_ff     <= P_W'(d2_ff) << (2 * rza_pkg::SCORE_FRAC);
            e_ff     <= P_W'(a_w) << (2 * (rza_pkg::SCORE_W - 1));
            vzero_ff <= (v_ff == '0);
            p_ff     <= '0;
            f_ff     <= '0;
            s_ff     <= '0;
            first_ff <= 1'b1;
            sat_ff   <= 1'b0;
         end
         rza_pkg::LN_SEARCH: begin
            // one score bit per step, MSB first; top bit saturates the rest
            if (take_w) begin
               p_ff <= cand_w;
               f_ff <= (f_ff >> 1) + e_ff;
            end else begin
               f_ff <= f_ff >> 1;
            end
            e_ff     <= e_ff >> 2;
            s_ff     <= {s_ff[rza_pkg::SCORE_W-2:0], take_w};
            sat_ff   <= sat_ff | (first_ff & take_w);
            first_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign score = vzero_ff ? '0 : s_ff;

endmodule

>>> hdl/rza_merge.sv
// Merge stage: largest lane score, zeroed for short runs.
module rza_merge (
   input  logic               clock,
   input  logic               load,
   input  rza_pkg::score_type lane_score [rza_pkg::NUM_LANES],
   input  logic               short_run,
   output rza_pkg::score_type best
);

   rza_pkg::score_type best_ff;
   rza_pkg::score_type max_w;

   // running maximum over the lanes
   always_comb begin
      max_w = '0;
      for (int i = 0; i < rza_pkg::NUM_LANES; i++) begin
         if (lane_score[i] > max_w) begin
            max_w = lane_score[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         best_ff <= short_run ? '0 : max_w;
      end
   end

   assign best = best_ff;

endmodule
